### rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared definitions for the parent pointer tree table
// Request and status codes, field widths, and the controller/datapath links.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int NODES_DEF = 16;
  localparam int NODE_W    = 4;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  // entry in ram: root flag on top, parent index below
  localparam int ENTRY_W   = NODE_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_CLEAR   = 3'd1,
    KIND_PARENT  = 3'd2,
    KIND_CHILD   = 3'd3,
    KIND_SIBLING = 3'd4,
    KIND_ROOT    = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EXISTS = 2'd1,
    ST_NONE   = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic look;
    logic scan;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic lookup;
    logic scan_kind;
    logic look_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/ppt_ram.sv
// ----------------------------------------------------------------------------
// ppt_ram: generic single write port ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl: request sequencer
// Steps one request through execute, entry lookup, table scan and finish.
// ----------------------------------------------------------------------------
module ppt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppt_pkg::sts_t sts,
  output ppt_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_LOOK = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.lookup) begin
          state_next = S_LOOK;
        end else if (sts.scan_kind) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = sts.look_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

### rtl/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp: table datapath
// Present bits, entry ram, scan pointer, match logic and output register.
// ----------------------------------------------------------------------------
module ppt_dp #(
  parameter int NODES = ppt_pkg::NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ppt_pkg::cmd_t                cmd,
  output ppt_pkg::sts_t                sts,
  input  logic [ppt_pkg::KIND_W-1:0]   kind,
  input  logic [ppt_pkg::NODE_W-1:0]   node,
  input  logic [ppt_pkg::NODE_W-1:0]   parent_node,
  input  logic                         as_root,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppt_pkg::STATUS_W-1:0] status,
  output logic [ppt_pkg::NODE_W-1:0]   answer
);

  localparam int IDX_W = $clog2(NODES);
  localparam int NW    = IDX_W + ppt_pkg::NODE_W;
  localparam logic [IDX_W:0] NODES_I = (IDX_W + 1)'(NODES);
  localparam logic [NW-1:0]  NODES_N = NW'(NODES);

  // request
  ppt_pkg::kind_t              kind_r;
  logic [ppt_pkg::NODE_W-1:0]  node_r;
  logic [ppt_pkg::NODE_W-1:0]  pnode_r;
  logic                        root_r;

  logic [NODES-1:0]            present;
  logic                        rd_present;
  logic [ppt_pkg::ENTRY_W-1:0] rdata;
  logic [ppt_pkg::ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]            raddr;
  logic                        we;

  logic [NW-1:0]               node_ext;
  logic [NW-1:0]               node_inc;
  logic [IDX_W-1:0]            node_addr;
  logic                        in_range;

  // scan pointers: iss is the next entry to read, chk the entry now on rdata
  logic [IDX_W:0]              iss;
  logic                        chk_vld;
  logic [IDX_W-1:0]            chk_idx;
  logic                        own_root;
  logic [ppt_pkg::NODE_W-1:0]  own_par;

  logic                        e_root;
  logic [ppt_pkg::NODE_W-1:0]  e_par;
  logic                        match;
  logic                        hit;
  logic                        scan_end;

  ppt_pkg::status_t            res_status;
  ppt_pkg::status_t            res_status_next;
  logic [ppt_pkg::NODE_W-1:0]  res_answer;
  logic [ppt_pkg::NODE_W-1:0]  res_answer_next;
  logic                        out_valid_r;
  ppt_pkg::status_t            status_r;
  logic [ppt_pkg::NODE_W-1:0]  answer_r;

  assign node_ext  = NW'(node_r);
  assign node_inc  = node_ext + NW'(1);
  assign node_addr = node_ext[IDX_W-1:0];
  assign in_range  = (node_ext < NODES_N);

  assign we    = cmd.exec && (kind_r == ppt_pkg::KIND_INSERT) && in_range
                 && !present[node_addr];
  assign wdata = {root_r, root_r ? ppt_pkg::NODE_W'(0) : pnode_r};
  assign raddr = cmd.scan ? iss[IDX_W-1:0] : node_addr;

  ppt_ram #(
    .WIDTH (ppt_pkg::ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (node_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e_root = rdata[ppt_pkg::ENTRY_W-1];
  assign e_par  = rdata[ppt_pkg::NODE_W-1:0];

  always_comb begin
    case (kind_r)
      ppt_pkg::KIND_CHILD:   match = rd_present && !e_root && (e_par == node_r);
      ppt_pkg::KIND_ROOT:    match = rd_present && e_root;
      ppt_pkg::KIND_SIBLING: match = rd_present && ((own_root || e_root)
                                     ? (own_root && e_root) : (e_par == own_par));
      default:               match = 1'b0;
    endcase
  end

  assign hit      = chk_vld && match;
  // once iss has run off the end, rdata holds the last entry
  assign scan_end = (iss >= NODES_I);

  assign sts.lookup    = (kind_r inside {ppt_pkg::KIND_PARENT, ppt_pkg::KIND_SIBLING});
  assign sts.scan_kind = (kind_r inside {ppt_pkg::KIND_CHILD, ppt_pkg::KIND_ROOT});
  assign sts.look_scan = (kind_r == ppt_pkg::KIND_SIBLING) && in_range && rd_present
                         && (node_inc < NODES_N);
  assign sts.scan_done = hit || scan_end;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    res_status_next = res_status;
    res_answer_next = res_answer;
    if (cmd.exec) begin
      res_answer_next = '0;
      case (kind_r)
        ppt_pkg::KIND_INSERT: begin
          if (!in_range) begin
            res_status_next = ppt_pkg::ST_NONE;
          end else if (present[node_addr]) begin
            res_status_next = ppt_pkg::ST_EXISTS;
          end else begin
            res_status_next = ppt_pkg::ST_DONE;
          end
        end
        ppt_pkg::KIND_CLEAR: res_status_next = ppt_pkg::ST_DONE;
        default:             res_status_next = ppt_pkg::ST_NONE;
      endcase
    end
    if (cmd.look) begin
      if ((kind_r == ppt_pkg::KIND_PARENT) && in_range && rd_present && !e_root) begin
        res_status_next = ppt_pkg::ST_DONE;
        res_answer_next = e_par;
      end else begin
        res_status_next = ppt_pkg::ST_NONE;
        res_answer_next = '0;
      end
    end
    if (cmd.scan) begin
      if (hit) begin
        res_status_next = ppt_pkg::ST_DONE;
        res_answer_next = ppt_pkg::NODE_W'(chk_idx);
      end else if (scan_end) begin
        res_status_next = ppt_pkg::ST_NONE;
        res_answer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present     <= '0;
      out_valid_r <= 1'b0;
      chk_vld     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (kind_r)
          ppt_pkg::KIND_INSERT: begin
            if (in_range && !present[node_addr]) begin
              present[node_addr] <= 1'b1;
            end
          end
          ppt_pkg::KIND_CLEAR: present <= '0;
          default: ;
        endcase
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      chk_vld <= cmd.scan && !scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= ppt_pkg::kind_t'(kind);
      node_r  <= node;
      pnode_r <= parent_node;
      root_r  <= as_root;
    end
    rd_present <= present[raddr];
    chk_idx    <= iss[IDX_W-1:0];
    if (cmd.exec) begin
      iss <= '0;
    end else if (cmd.look) begin
      iss      <= (IDX_W + 1)'(node_inc);
      own_root <= e_root;
      own_par  <= e_par;
    end else if (cmd.scan && !scan_end) begin
      iss <= iss + (IDX_W + 1)'(1);
    end
    res_status <= res_status_next;
    res_answer <= res_answer_next;
    if (cmd.fin) begin
      status_r <= res_status;
      answer_r <= res_answer;
    end
  end

  assign out_valid = out_valid_r;
  assign status    = status_r;
  assign answer    = answer_r;

endmodule

### rtl/parent_pointer_tree_table.sv
// ----------------------------------------------------------------------------
// parent_pointer_tree_table: forest kept as a per-node parent table
// Insert, clear, and parent/child/sibling/root queries, one request at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one request item: kind, node,
// parent_node, as_root. Output channel (out_valid/out_stall) carries one
// result item per request: status and answer.
// Insert, clear and unused kinds pass through execute and finish; parent adds
// an entry lookup; leftmost child and root scan the entries from entry 0 up;
// right sibling looks the node up, then scans the entries above the node.
// Scans read the entry ram one entry per cycle through its single read port.
// The next item is taken only once the result of the last one has entered
// the output register, so the block never works on two requests at once.
// A finished result waits in the output register while out_stall is high;
// the block holds the next result in its finish state until that slot frees.
// Reset (rst, synchronous) clears all present bits together and empties
// the output register; the table reads as all absent right away, no sweep.
// ----------------------------------------------------------------------------
module parent_pointer_tree_table #(
  parameter int NODES = ppt_pkg::NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppt_pkg::KIND_W-1:0]   kind,
  input  logic [ppt_pkg::NODE_W-1:0]   node,
  input  logic [ppt_pkg::NODE_W-1:0]   parent_node,
  input  logic                         as_root,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppt_pkg::STATUS_W-1:0] status,
  output logic [ppt_pkg::NODE_W-1:0]   answer
);

  ppt_pkg::cmd_t cmd;
  ppt_pkg::sts_t sts;

  ppt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppt_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .node        (node),
    .parent_node (parent_node),
    .as_root     (as_root),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .answer      (answer)
  );

endmodule

### rtl/ppt_checker.sv
// ----------------------------------------------------------------------------
// ppt_checker: port level checks for the parent pointer tree table
// Watches the two channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ppt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ppt_pkg::STATUS_W-1:0] status,
  input logic [ppt_pkg::NODE_W-1:0]   answer
);

  // one request at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(answer)))
    else $error("stalled result changed");

  // answer only carries an index on a hit
  a_answer_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ppt_pkg::ST_DONE)) |-> (answer == '0))
    else $error("answer nonzero without a hit");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("not idle after reset");

endmodule

bind parent_pointer_tree_table ppt_checker u_ppt_checker (.*);
